/* hdl/cle_pkg.sv */
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the cursor list engine
// Word layouts, operation codes and per-cell commands.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [7:0] FILL_CHAR = 8'h20;

    typedef enum logic [3:0] {
        FN_INS_BEFORE = 4'd0,
        FN_INS_AFTER  = 4'd1,
        FN_ERASE      = 4'd2,
        FN_REPLACE    = 4'd3,
        FN_READ       = 4'd4,
        FN_FRONT      = 4'd5,
        FN_END        = 4'd6,
        FN_PREV       = 4'd7,
        FN_NEXT       = 4'd8,
        FN_NEXT_WRAP  = 4'd9,
        FN_SET_POS    = 4'd10,
        FN_REVERSE    = 4'd11,
        FN_CLEAR      = 4'd12
    } func_t;

    typedef struct packed {
        logic [3:0]       func;
        logic [7:0]       value;
        logic [IDX_W-1:0] index;
    } in_word_t;

    typedef struct packed {
        logic             ok;
        logic [7:0]       element;
        logic [IDX_W-1:0] cursor;
        logic [CNT_W-1:0] count;
    } out_word_t;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_WRITE,
        CELL_MIRROR,
        CELL_SHIFT_DN,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [7:0]       value;
    } cell_ctrl_t;

endpackage

/* hdl/cle_cell.sv */
// ----------------------------------------------------------------------------
// cle_cell: one slot of the list
// Holds one entry and picks its next value from itself, its neighbors,
// its mirror slot, the broadcast value or a space.
// ----------------------------------------------------------------------------
module cle_cell
    import cle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] slot,
    input  cell_ctrl_t       ctrl,
    input  logic [7:0]       lo_data,
    input  logic [7:0]       hi_data,
    input  logic [7:0]       mirror_data,
    output logic [7:0]       data
);

    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic [CNT_W-1:0] slot_ext;
    logic [CNT_W-1:0] slot_inc;
    logic [CNT_W-1:0] pos_ext;

    assign slot_ext = {1'b0, slot};
    assign slot_inc = slot_ext + 1'b1;
    assign pos_ext  = {1'b0, ctrl.pos};

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (slot == ctrl.pos)
                    data_next = ctrl.value;
                else if (slot_ext > pos_ext && slot_ext <= ctrl.count)
                    data_next = lo_data;
            end
            CELL_ERASE:
            begin
                if (slot_inc == ctrl.count)
                    data_next = FILL_CHAR;
                else if (slot_ext >= pos_ext && slot_inc < ctrl.count)
                    data_next = hi_data;
            end
            CELL_WRITE:
            begin
                if (slot == ctrl.pos)
                    data_next = ctrl.value;
            end
            CELL_MIRROR:   data_next = mirror_data;
            CELL_SHIFT_DN: data_next = hi_data;
            CELL_CLEAR:    data_next = FILL_CHAR;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= FILL_CHAR;
        else
            data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hdl/cursor_list_engine_core.sv */
// ----------------------------------------------------------------------------
// cursor_list_engine_core: byte list with a cursor
// Each accepted word goes through S_RESP into the output register; one word in flight.
// A reverse on n >= 2 entries mirrors the row, then S_SHIFT shifts it down one
// slot at a time until the entries start at slot 0 again.
// Reset: all entries are spaces, cursor and count are 0, no output valid.
// ----------------------------------------------------------------------------
module cursor_list_engine_core
    import cle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ok_reg, ok_next;
    logic [CNT_W-1:0] shift_reg, shift_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    cell_ctrl_t       ctrl;
    logic [7:0]       cell_data [CAPACITY];

    logic             accept;
    logic [CNT_W-1:0] cur_ext;
    logic [CNT_W-1:0] cur_inc_ext;
    logic [IDX_W-1:0] cur_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] idx_ext;
    logic             nonempty;
    logic             on_entry;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign cur_ext     = {1'b0, cur_reg};
    assign cur_inc_ext = cur_ext + 1'b1;
    assign cur_inc     = cur_reg + 1'b1;
    assign cnt_dec     = cnt_reg - 1'b1;
    assign idx_ext     = {1'b0, in_word.index};
    assign nonempty    = (cnt_reg != '0);
    assign on_entry    = (cur_ext < cnt_reg);

    // cell row
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [7:0] lo_d;
            logic [7:0] hi_d;
            if (g == 0)
            begin : g_bot
                assign lo_d = FILL_CHAR;
            end
            else
            begin : g_lo
                assign lo_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_top
                assign hi_d = FILL_CHAR;
            end
            else
            begin : g_hi
                assign hi_d = cell_data[g+1];
            end
            cle_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .slot        (IDX_W'(g)),
                .ctrl        (ctrl),
                .lo_data     (lo_d),
                .hi_data     (hi_d),
                .mirror_data (cell_data[CAPACITY-1-g]),
                .data        (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        ok_next        = ok_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.pos       = cur_reg;
        ctrl.count     = cnt_reg;
        ctrl.value     = in_word.value;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESP;
                    case (in_word.func)
                        FN_INS_BEFORE, FN_INS_AFTER:
                        begin
                            if (!nonempty)
                            begin
                                ctrl.op  = CELL_INSERT;
                                ctrl.pos = '0;
                                cnt_next = CNT_W'(1);
                                cur_next = '0;
                                ok_next  = 1'b1;
                            end
                            else if (cnt_reg < CNT_W'(CAPACITY))
                            begin
                                ctrl.op  = CELL_INSERT;
                                ctrl.pos = (in_word.func == FN_INS_BEFORE) ? cur_reg : cur_inc;
                                cnt_next = cnt_reg + 1'b1;
                                cur_next = ctrl.pos;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_ERASE:
                        begin
                            if (nonempty)
                            begin
                                ctrl.op  = CELL_ERASE;
                                cnt_next = cnt_dec;
                                if (cur_ext == cnt_dec && cur_reg != '0)
                                    cur_next = cur_reg - 1'b1;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_REPLACE:
                        begin
                            if (on_entry)
                            begin
                                ctrl.op = CELL_WRITE;
                                ok_next = 1'b1;
                            end
                        end
                        FN_READ:
                            ok_next = on_entry;
                        FN_FRONT:
                        begin
                            if (nonempty)
                            begin
                                cur_next = '0;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_END:
                        begin
                            if (nonempty)
                            begin
                                cur_next = cnt_dec[IDX_W-1:0];
                                ok_next  = 1'b1;
                            end
                        end
                        FN_PREV:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - 1'b1;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_NEXT:
                        begin
                            if (cur_inc_ext < cnt_reg)
                            begin
                                cur_next = cur_inc;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_NEXT_WRAP:
                        begin
                            if (nonempty)
                            begin
                                cur_next = (cur_inc_ext < cnt_reg) ? cur_inc : '0;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_SET_POS:
                        begin
                            if (idx_ext < cnt_reg)
                            begin
                                cur_next = in_word.index;
                                ok_next  = 1'b1;
                            end
                        end
                        FN_REVERSE:
                        begin
                            ok_next = 1'b1;
                            // mirror the whole row, then slide the entries back down
                            if (cnt_reg > CNT_W'(1))
                            begin
                                ctrl.op    = CELL_MIRROR;
                                shift_next = CNT_W'(CAPACITY) - cnt_reg;
                                if (shift_next != '0)
                                    state_next = S_SHIFT;
                            end
                        end
                        FN_CLEAR:
                        begin
                            ctrl.op  = CELL_CLEAR;
                            cnt_next = '0;
                            cur_next = '0;
                            ok_next  = 1'b1;
                        end
                        default:
                            ok_next = 1'b0;
                    endcase
                end
            end
            S_SHIFT:
            begin
                ctrl.op    = CELL_SHIFT_DN;
                shift_next = shift_reg - 1'b1;
                if (shift_reg == CNT_W'(1))
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.ok      = ok_reg;
                    out_next.element = on_entry ? cell_data[cur_reg] : 8'h00;
                    out_next.cursor  = cur_reg;
                    out_next.count   = cnt_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            ok_reg        <= 1'b0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            ok_reg        <= ok_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // cursor sits on an entry, or the list is empty with cursor at 0
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_ext < cnt_reg) || (cur_reg == '0 && cnt_reg == '0))
        else $error("cursor outside the list");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (shift_reg != '0))
        else $error("shift state with nothing left to shift");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_word.func == FN_CLEAR) |=> (cnt_reg == '0 && cur_reg == '0))
        else $error("clear left entries behind");

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !out_valid_reg) |=> out_valid_reg)
        else $error("result not delivered to output register");

endmodule
